### hw/rtl/zcpm_pkg.sv
// zcpm_pkg: shared constants and types of the zero crossing period meter
`timescale 1ns / 1ps
`default_nettype none

package zcpm_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int TICK_W = 32;
  localparam int SUM_W  = 42;
  localparam int CNT_W  = 10;

  localparam logic [CNT_W-1:0] PERIODS_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAC,
    ST_AVG,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### hw/rtl/zcpm_div.sv
// zcpm_div: radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module zcpm_div #(
  parameter int DIVIDEND_W = 42,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int CW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIVIDEND_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### hw/rtl/zero_crossing_period_meter_top.sv
// zero_crossing_period_meter_top: rising zero crossing period meter with averaging
`timescale 1ns / 1ps
`default_nettype none

// One result beat per sample beat. Periods are unsigned fixed point with
// FRACTION_BITS fraction bits, the fraction found by linear interpolation
// across zero. All divisions run on one shared radix-2 divider that yields
// one quotient bit per cycle over DIV_W = max(42, SAMPLE_BITS + FRACTION_BITS)
// bits (42 at the defaults). A sample without a crossing goes straight to the
// result stage, a crossing first runs the interpolation pass of the divider,
// and a crossing that closes an averaging group runs a second pass for the
// average. Samples are taken one at a time; the result register lets the next
// sample in while a result still waits downstream.
module zero_crossing_period_meter_top #(
  parameter int SAMPLE_BITS   = zcpm_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = zcpm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [zcpm_pkg::CNT_W-1:0]           cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      crossing_seen_o,
  output logic [zcpm_pkg::TICK_W-1:0]               period_value_o,
  output logic                                      average_ready_o,
  output logic [zcpm_pkg::TICK_W-1:0]               average_period_o
);

  import zcpm_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int DIV_W = (SUM_W > SB + FB) ? SUM_W : SB + FB;
  localparam int DV_W  = (SB > CNT_W) ? SB : CNT_W;
  localparam logic [TICK_W-1:0] ONE_TICK = TICK_W'(1) << FB;

  state_e state_q, state_d;

  logic signed [SB-1:0] prev_q, prev_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TICK_W-1:0]    last_period_q, last_period_d;
  logic [TICK_W-1:0]    last_avg_q, last_avg_d;
  logic [CNT_W-1:0]     pta_q;
  logic                 cross_q, cross_d;
  logic                 ready_q, ready_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_cross_q;
  logic                 out_ready_q;
  logic [TICK_W-1:0]    out_period_q;
  logic [TICK_W-1:0]    out_avg_q;

  logic                 accept;
  logic                 crossing_in;
  logic [SB:0]          neg_w;
  logic [SB:0]          delta_w;
  logic [TICK_W-1:0]    frac;
  logic [TICK_W:0]      period_w;
  logic [TICK_W-1:0]    period_sat;
  logic [SUM_W:0]       sum_w;
  logic [SUM_W-1:0]     sum_sat;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     n_eff;
  logic                 group_full;
  logic [TICK_W-1:0]    q_sat;
  logic [TICK_W:0]      tick_w;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_W-1:0]     div_dividend;
  logic [DV_W-1:0]      div_divisor;
  logic [DIV_W-1:0]     div_quo;
  logic                 out_load;

  assign accept      = in_valid_i && !in_stall_o;
  assign crossing_in = prev_q[SB-1] && !sample_i[SB-1];
  assign neg_w       = (SB+1)'(0) - {prev_q[SB-1], prev_q};
  assign delta_w     = {sample_i[SB-1], sample_i} - {prev_q[SB-1], prev_q};

  assign frac       = div_quo[TICK_W-1:0];
  assign period_w   = {1'b0, tick_q} + {1'b0, frac};
  assign period_sat = period_w[TICK_W] ? '1 : period_w[TICK_W-1:0];
  assign sum_w      = {1'b0, sum_q} + (SUM_W+1)'(period_sat);
  assign sum_sat    = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign n_eff      = (pta_q == '0) ? CNT_W'(1) : pta_q;
  assign group_full = cnt_inc >= n_eff;
  assign q_sat      = (|div_quo[DIV_W-1:TICK_W]) ? '1 : div_quo[TICK_W-1:0];
  assign tick_w     = {1'b0, tick_q} + {1'b0, ONE_TICK};

  // divider operands: interpolation at accept, average after the frac pass
  always_comb begin
    if (state_q == ST_IDLE) begin
      div_dividend = DIV_W'({neg_w[SB-1:0], FB'(0)});
      div_divisor  = DV_W'(delta_w[SB-1:0]);
    end else begin
      div_dividend = DIV_W'(sum_sat);
      div_divisor  = DV_W'(n_eff);
    end
  end

  zcpm_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = crossing_in ? ST_FRAC : ST_DONE;
        end
      end
      ST_FRAC: begin
        if (div_done) begin
          state_d = group_full ? ST_AVG : ST_DONE;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    div_start  = (accept && crossing_in) ||
                 ((state_q == ST_FRAC) && div_done && group_full);
  end

  // datapath
  always_comb begin
    prev_d        = prev_q;
    tick_d        = tick_q;
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    last_period_d = last_period_q;
    last_avg_d    = last_avg_q;
    cross_d       = cross_q;
    ready_d       = ready_q;
    out_valid_d   = out_valid_q && out_stall_i;
    if (accept) begin
      prev_d  = sample_i;
      cross_d = crossing_in;
      ready_d = 1'b0;
    end
    if ((state_q == ST_FRAC) && div_done) begin
      last_period_d = period_sat;
      tick_d        = ONE_TICK - frac;
      if (group_full) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_sat;
        cnt_d = cnt_inc;
      end
    end
    if ((state_q == ST_AVG) && div_done) begin
      last_avg_d = (q_sat > ONE_TICK) ? q_sat - ONE_TICK : '0;
      ready_d    = 1'b1;
    end
    if (out_load) begin
      tick_d      = tick_w[TICK_W] ? '1 : tick_w[TICK_W-1:0];
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      prev_q        <= '0;
      tick_q        <= '0;
      sum_q         <= '0;
      cnt_q         <= '0;
      last_period_q <= '0;
      last_avg_q    <= '0;
      pta_q         <= PERIODS_RESET;
      cross_q       <= 1'b0;
      ready_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      prev_q        <= prev_d;
      tick_q        <= tick_d;
      sum_q         <= sum_d;
      cnt_q         <= cnt_d;
      last_period_q <= last_period_d;
      last_avg_q    <= last_avg_d;
      cross_q       <= cross_d;
      ready_q       <= ready_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        pta_q <= cfg_wdata_i;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cross_q  <= cross_q;
      out_ready_q  <= ready_q;
      out_period_q <= last_period_q;
      out_avg_q    <= last_avg_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign crossing_seen_o  = out_cross_q;
  assign period_value_o   = out_period_q;
  assign average_ready_o  = out_ready_q;
  assign average_period_o = out_avg_q;

endmodule

`default_nettype wire

### hw/rtl/zcpm_checker.sv
// zcpm_checker: port level assertions for the period meter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module zcpm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        crossing_seen_o,
  input wire logic [zcpm_pkg::TICK_W-1:0] period_value_o,
  input wire logic                        average_ready_o,
  input wire logic [zcpm_pkg::TICK_W-1:0] average_period_o
);

  import zcpm_pkg::*;

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample beat accepted while another was in flight");

  // an average only comes with a crossing
  a_avg_needs_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && average_ready_o |-> crossing_seen_o)
    else $error("average ready without a crossing");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(period_value_o) && $stable(average_period_o))
    else $error("result beat changed while stalled");

endmodule

bind zero_crossing_period_meter_top zcpm_checker u_zcpm_checker (.*);

`default_nettype wire
